// File: sv/lfg_pkg.sv
`default_nettype none
package lfg_pkg;

  localparam int unsigned CountWidth = 16;
  localparam logic [CountWidth-1:0] PERIOD = 16'd512;

  localparam logic [7:0] TOP_LEVEL    = 8'd255;
  localparam logic [7:0] BOTTOM_LEVEL = 8'd128;
  localparam logic [7:0] FLOOR_LEVEL  = 8'd60;
  localparam logic [7:0] DIP_LEN      = 8'd128;
  localparam logic [7:0] SLOPE        = 8'd127;

  localparam logic [31:0] SEED0 = 32'd123456789;
  localparam logic [31:0] SEED1 = 32'd362436069;
  localparam logic [31:0] SEED2 = 32'd521288629;
  localparam logic [31:0] SEED3 = 32'd88675123;

endpackage
`default_nettype wire

// File: sv/led_flicker_generator_core.sv
// channel  dir  handshake                data
// s        in   s_tvalid / s_tready      s_tdata[7:0]  ceiling
// m        out  m_tvalid / m_tready      m_tdata[7:0]  brightness
// cfg      in   cfg_valid / cfg_ready    cfg_data[7:0] enable_level
//
// a tick passes through S_MUL1, S_MUL2, S_DIV and S_DONE into the output register (a period
// end adds S_RNG first for the generator step); the sequencer shares one 8x8 multiplier.
// the next tick is taken only once the sequencer is back in S_IDLE, so no new tick is accepted while one is in flight.
// a disabled tick goes straight from S_IDLE to S_DONE.
// rst (synchronous) restores the seed words, enable level 255 and the counter.
// the finished result sits in the output register while m_tready is low.
`default_nettype none
module led_flicker_generator_core
  import lfg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] ceiling
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] brightness
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data   // [7:0] enable_level
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RNG  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state;
  logic [7:0]            enable_level;
  logic [CountWidth-1:0] tick_count;
  logic [6:0]            dip_start;
  logic [31:0]           w0, w1, w2, w3;
  logic [7:0]            maxb;
  logic                  in_win;
  logic                  rising;
  logic [15:0]           prod;
  logic [7:0]            res;

  logic [7:0]            mul_a, mul_b;
  logic [15:0]           mul_p;
  logic [31:0]           rng_t, rng_w3_next;
  logic [CountWidth-1:0] win_end, k_full;
  logic [7:0]            level;
  logic [16:0]           div_sum;
  logic [7:0]            quot;
  logic                  load_res;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = res;

  // output register takes a new result when empty or being drained
  assign load_res = (state == S_DONE) && (!m_tvalid || m_tready);

  // xorshift128 step
  assign rng_t       = w0 ^ (w0 << 11);
  assign rng_w3_next = w3 ^ (w3 >> 19) ^ rng_t ^ (rng_t >> 8);

  assign win_end = CountWidth'(dip_start) + CountWidth'(DIP_LEN);
  assign k_full  = tick_count - CountWidth'(dip_start);

  always_comb begin
    if (!in_win) begin
      level = TOP_LEVEL;
    end else if (rising) begin
      level = BOTTOM_LEVEL + prod[13:6];
    end else begin
      level = TOP_LEVEL - prod[13:6];
    end
  end

  // shared multiplier: slope step first, then brightness scaling
  always_comb begin
    if (state == S_MUL1) begin
      mul_a = SLOPE;
      mul_b = {2'b00, k_full[5:0]};
    end else begin
      mul_a = level;
      mul_b = maxb;
    end
  end
  assign mul_p = mul_a * mul_b;

  // floor(x/255) for x a product of two 8-bit values (up to 65025)
  assign div_sum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
  assign quot    = div_sum[15:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      enable_level <= 8'd255;
      tick_count   <= PERIOD;
      dip_start    <= 7'd0;
      w0           <= SEED0;
      w1           <= SEED1;
      w2           <= SEED2;
      w3           <= SEED3;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        enable_level <= cfg_data;
      end
      if (load_res) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            maxb <= s_tdata;
            priority if (enable_level == 8'd0) begin
              prod  <= 16'd0;
              state <= S_DONE;
            end else if (tick_count >= PERIOD) begin
              state <= S_RNG;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_RNG: begin
          w0         <= w1;
          w1         <= w2;
          w2         <= w3;
          w3         <= rng_w3_next;
          dip_start  <= rng_w3_next[6:0];
          tick_count <= '0;
          state      <= S_MUL1;
        end
        S_MUL1: begin
          in_win <= (tick_count >= CountWidth'(dip_start)) && (tick_count < win_end);
          rising <= k_full[6];
          prod   <= mul_p;
          state  <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= mul_p;
          state <= S_DIV;
        end
        S_DIV: begin
          prod       <= {8'd0, (quot < FLOOR_LEVEL) ? FLOOR_LEVEL : quot};
          tick_count <= tick_count + CountWidth'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (load_res) begin
            res   <= prod[7:0];
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/led_flicker_generator_checker.sv
`default_nettype none
module led_flicker_generator_checker
  import lfg_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // brightness is zero (disabled) or at least the floor
  a_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'd0) || (m_tdata >= FLOOR_LEVEL))
    else $error("brightness below floor");

  // a request busies the sequencer for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // no result right after a request: the sequencer passes through S_DONE before the output register loads
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result too early");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("bad state after reset");

endmodule

bind led_flicker_generator_core led_flicker_generator_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
